// ===== rtl/pointer_motion_smoother_top_defines.svh =====
// Assertion macros shared by the pointer motion smoother RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef POINTER_MOTION_SMOOTHER_TOP_DEFINES_SVH
`define POINTER_MOTION_SMOOTHER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PMS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define PMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pms_pkg.sv =====
// Shared types, widths and register indexes for the pointer motion smoother.
// Used by pms_gain, pms_filter and pointer_motion_smoother_top; no dependencies.
`timescale 1ns / 1ps

package pms_pkg;

	// Field and register widths
	localparam int DELTA_WIDTH = 16;  // low bits of each raw delta that are used
	localparam int MOVE_W      = 16;
	localparam int OUT_W       = 16;
	localparam int GAIN_W      = 4;
	localparam int SHIFT_W     = 3;
	localparam int DZ_W        = 8;
	localparam int STOP_W      = 8;
	localparam int FILT_W      = 21;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STOP     = 2'd3;

	// Reset values of the registers
	localparam logic [GAIN_W-1:0]  GAIN_RST     = 4'd2;
	localparam logic [SHIFT_W-1:0] SHIFT_RST    = 3'd1;
	localparam logic [DZ_W-1:0]    DEADZONE_RST = 8'd5;
	localparam logic [STOP_W-1:0]  STOP_RST     = 8'd8;

	// Gained delta of one axis plus its idle flag (magnitude at most the deadzone)
	typedef struct packed {
		logic signed [FILT_W-1:0] value;
		logic                     idle;
	} gain_t;

	// Live configuration
	typedef struct packed {
		logic [GAIN_W-1:0]  gain;
		logic [SHIFT_W-1:0] shift;
		logic [DZ_W-1:0]    deadzone;
		logic [STOP_W-1:0]  stop;
	} cfg_t;

endpackage

// ===== rtl/pms_gain.sv =====
// Per-axis gain and deadzone: sign-extends the raw delta, scales it and gates small values.
// Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_gain (
	input  logic signed [pms_pkg::MOVE_W-1:0] raw,
	input  logic [pms_pkg::GAIN_W-1:0]        gain,
	input  logic [pms_pkg::DZ_W-1:0]          deadzone,
	output pms_pkg::gain_t                    result
);

	logic signed [pms_pkg::FILT_W-1:0] delta;
	logic signed [pms_pkg::FILT_W-1:0] gain_ext;
	logic signed [pms_pkg::FILT_W-1:0] prod;
	logic        [pms_pkg::FILT_W-1:0] mag;
	logic        [pms_pkg::FILT_W-1:0] dz_ext;

	// Take the low delta bits and sign-extend them
	assign delta = {{(pms_pkg::FILT_W-pms_pkg::DELTA_WIDTH){raw[pms_pkg::DELTA_WIDTH-1]}},
		raw[pms_pkg::DELTA_WIDTH-1:0]};
	assign gain_ext = $signed({{(pms_pkg::FILT_W-pms_pkg::GAIN_W){1'b0}}, gain});

	// Scale; the product of a 16-bit delta and a 4-bit gain fits in 21 bits
	assign prod = delta * gain_ext;

	// Magnitude against the deadzone
	assign mag    = prod[pms_pkg::FILT_W-1] ? $unsigned(-prod) : $unsigned(prod);
	assign dz_ext = {{(pms_pkg::FILT_W-pms_pkg::DZ_W){1'b0}}, deadzone};

	// Drop values below the deadzone; flag idle up to and including it
	assign result.value = (mag < dz_ext) ? '0 : prod;
	assign result.idle  = (mag <= dz_ext);

endmodule

// ===== rtl/pms_filter.sv =====
// Per-axis exponential moving-average filter with stop snap and 16-bit saturation.
// Holds the filter state register. Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_filter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  pms_pkg::gain_t                   gained,
	input  logic [pms_pkg::SHIFT_W-1:0]      shift,
	input  logic [pms_pkg::STOP_W-1:0]       stop,
	output logic signed [pms_pkg::OUT_W-1:0] smooth
);

	localparam int DIFF_W = pms_pkg::FILT_W + 1;
	localparam logic signed [pms_pkg::FILT_W-1:0] OUT_MAX =
		$signed({{(pms_pkg::FILT_W-pms_pkg::OUT_W+1){1'b0}}, {(pms_pkg::OUT_W-1){1'b1}}});
	localparam logic signed [pms_pkg::FILT_W-1:0] OUT_MIN =
		$signed({{(pms_pkg::FILT_W-pms_pkg::OUT_W+1){1'b1}}, {(pms_pkg::OUT_W-1){1'b0}}});

	logic signed [pms_pkg::FILT_W-1:0] filter_q;
	logic signed [DIFF_W-1:0]          diff;
	logic        [DIFF_W-1:0]          round_mask;
	logic signed [DIFF_W-1:0]          diff_adj;
	logic signed [DIFF_W-1:0]          step;
	logic signed [pms_pkg::FILT_W-1:0] filt_new;
	logic signed [pms_pkg::FILT_W-1:0] stop_ext;
	logic                              snap;
	logic signed [pms_pkg::FILT_W-1:0] filt_next;

	// Difference toward the gained value, divided by 2^shift rounding toward zero
	assign diff       = {gained.value[pms_pkg::FILT_W-1], gained.value}
		- {filter_q[pms_pkg::FILT_W-1], filter_q};
	assign round_mask = ~({DIFF_W{1'b1}} << shift);
	assign diff_adj   = diff + (diff[DIFF_W-1] ? $signed(round_mask) : $signed({DIFF_W{1'b0}}));
	assign step       = diff_adj >>> shift;

	// New filter value stays between the old value and the gained value
	assign filt_new = filter_q + step[pms_pkg::FILT_W-1:0];

	// Snap an idle axis to zero inside the stop band
	assign stop_ext  = $signed({{(pms_pkg::FILT_W-pms_pkg::STOP_W){1'b0}}, stop});
	assign snap      = gained.idle && (filt_new > -stop_ext) && (filt_new < stop_ext);
	assign filt_next = snap ? '0 : filt_new;

	// Clamp to the signed output range
	always_comb begin
		if (filt_next > OUT_MAX) begin
			smooth = OUT_MAX[pms_pkg::OUT_W-1:0];
		end else if (filt_next < OUT_MIN) begin
			smooth = OUT_MIN[pms_pkg::OUT_W-1:0];
		end else begin
			smooth = filt_next[pms_pkg::OUT_W-1:0];
		end
	end

	// Advance the state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= '0;
		end else if (en) begin
			filter_q <= filt_next;
		end
	end

endmodule

// ===== rtl/pointer_motion_smoother_top.sv =====
// Pointer motion smoother: top level with stream ports and configuration registers.
// Instantiates pms_gain and pms_filter per axis; depends on pms_pkg and the
// assertion macros in pointer_motion_smoother_top_defines.svh.
//
// Usage:
//   Input stream s_axis carries one motion report per word (X and Y deltas);
//   output stream m_axis returns one smoothed report per input word, in order.
//   Registers are written through cfg_we/cfg_idx/cfg_data: 0 gain, 1 smoothing
//   shift, 2 input deadzone, 3 stop threshold. Write them only while idle.
//   An accepted word passes through the input register and then the output
//   register before it appears on m_axis. Throughput: one word per cycle
//   while m_axis_tready stays high. The gain stage is registered, then the
//   filter update and the output register close the loop on the per-axis
//   filter state in the same cycle, so reports can follow back to back.
//   Stall: when m_axis_tready is low the output word holds; the input stage
//   can still take one more word, after which s_axis_tready drops until the
//   output is taken.
//   Reset (arst_n low, asynchronous): both filters clear to zero, registers
//   return to gain 2, shift 1, deadzone 5, stop threshold 8, and both stream
//   stages empty.
`timescale 1ns / 1ps
`include "pointer_motion_smoother_top_defines.svh"

module pointer_motion_smoother_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [2*pms_pkg::MOVE_W-1:0]      s_axis_tdata,  // [15:0] move_x, [31:16] move_y
	// output stream
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [2*pms_pkg::OUT_W-1:0]       m_axis_tdata,  // [15:0] smooth_x, [31:16] smooth_y
	// configuration
	input  logic                              cfg_we,
	input  logic [pms_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [pms_pkg::CFG_DATA_W-1:0]    cfg_data
);

	pms_pkg::cfg_t cfg_q;

	pms_pkg::gain_t gain_x, gain_y;
	pms_pkg::gain_t gain_x_s1, gain_y_s1;
	logic           valid_s1;
	logic           adv;

	logic signed [pms_pkg::OUT_W-1:0] smooth_x, smooth_y;
	logic [2*pms_pkg::OUT_W-1:0]      data_s2;
	logic                             valid_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain     <= pms_pkg::GAIN_RST;
			cfg_q.shift    <= pms_pkg::SHIFT_RST;
			cfg_q.deadzone <= pms_pkg::DEADZONE_RST;
			cfg_q.stop     <= pms_pkg::STOP_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				pms_pkg::REG_GAIN:     cfg_q.gain     <= cfg_data[pms_pkg::GAIN_W-1:0];
				pms_pkg::REG_SHIFT:    cfg_q.shift    <= cfg_data[pms_pkg::SHIFT_W-1:0];
				pms_pkg::REG_DEADZONE: cfg_q.deadzone <= cfg_data[pms_pkg::DZ_W-1:0];
				pms_pkg::REG_STOP:     cfg_q.stop     <= cfg_data[pms_pkg::STOP_W-1:0];
				default: ;
			endcase
		end
	end

	// Gain and deadzone ahead of the input register
	pms_gain u_gain_x (
		.raw      (s_axis_tdata[pms_pkg::MOVE_W-1:0]),
		.gain     (cfg_q.gain),
		.deadzone (cfg_q.deadzone),
		.result   (gain_x)
	);

	pms_gain u_gain_y (
		.raw      (s_axis_tdata[2*pms_pkg::MOVE_W-1:pms_pkg::MOVE_W]),
		.gain     (cfg_q.gain),
		.deadzone (cfg_q.deadzone),
		.result   (gain_y)
	);

	// Handshake: stage 1 moves on when the output register is free or being taken
	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			gain_x_s1 <= gain_x;
			gain_y_s1 <= gain_y;
		end
	end

	// Filter update per axis, state advances with the word
	pms_filter u_filter_x (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.gained (gain_x_s1),
		.shift  (cfg_q.shift),
		.stop   (cfg_q.stop),
		.smooth (smooth_x)
	);

	pms_filter u_filter_y (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.gained (gain_y_s1),
		.shift  (cfg_q.shift),
		.stop   (cfg_q.stop),
		.smooth (smooth_y)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s2 <= {smooth_y, smooth_x};
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = data_s2;

	// Checks
	`PMS_ASSERT_NEXT(a_adv_fills_out, clk, arst_n, adv, m_axis_tvalid,
		"advanced word did not reach the output register")
	`PMS_ASSERT_IMPL(a_ready_low_only_full, clk, arst_n, !s_axis_tready,
		valid_s1 && m_axis_tvalid && !m_axis_tready,
		"input stalled while a stage could move")
	`PMS_ASSERT_IMPL(a_empty_out_takes_input, clk, arst_n, !m_axis_tvalid, s_axis_tready,
		"input not ready with an empty output register")

endmodule
